### design/erws_pkg.sv
package erws_pkg;

   // Node table geometry.
   localparam int NODE_COUNT  = 8;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int IDX_W       = $clog2(NODE_COUNT + 1);
   localparam int CLASS_COUNT = 3;
   localparam int CLS_W       = 2;

   // Request function codes.
   localparam logic [2:0] FUNC_PEER     = 3'd0;
   localparam logic [2:0] FUNC_STATUS   = 3'd1;
   localparam logic [2:0] FUNC_INFER    = 3'd2;
   localparam logic [2:0] FUNC_FEEDBACK = 3'd3;
   localparam logic [2:0] FUNC_REFRESH  = 3'd4;

   // Control register indexes (byte address is four times the index).
   localparam int         CSR_ADDR_W       = 5;
   localparam logic [2:0] REG_OWN_NODE     = 3'd0;
   localparam logic [2:0] REG_COLD_LIMIT   = 3'd1;
   localparam logic [2:0] REG_WARM_LIMIT   = 3'd2;
   localparam logic [2:0] REG_UNKNOWN_RTT  = 3'd3;
   localparam logic [2:0] REG_MS_PER_POINT = 3'd4;

   // Reset values of the control registers.
   localparam logic [7:0]  OWN_NODE_RESET     = 8'd255;
   localparam logic [7:0]  COLD_LIMIT_RESET   = 8'd20;
   localparam logic [7:0]  WARM_LIMIT_RESET   = 8'd35;
   localparam logic [31:0] UNKNOWN_RTT_RESET  = 32'd1000;
   localparam logic [31:0] MS_PER_POINT_RESET = 32'd10;

   localparam logic [7:0]  OWN_UNASSIGNED = 8'hFF;
   localparam logic [31:0] RTT_UNKNOWN    = 32'hFFFF_FFFF;
   localparam logic [7:0]  DEFAULT_ACC    = 8'd50;
   localparam logic [7:0]  ACC_SATURATED  = 8'hFF;
   localparam logic [6:0]  PCT_SCALE      = 7'd100;

   // Divider geometry: an 8-bit quotient with a saturation flag.
   localparam int QUO_W      = 8;
   localparam int DIV_DEN_W  = 33;
   localparam int DIV_NUM_W  = DIV_DEN_W + QUO_W;
   localparam int PROD_W     = 39;
   localparam int STEP_W     = $clog2(QUO_W + 1);

   typedef struct packed {
      logic [7:0]        own_node;
      logic signed [7:0] cold_limit;
      logic signed [7:0] warm_limit;
      logic [31:0]       unknown_rtt_ms;
      logic [31:0]       ms_per_point;
   } cfg_type;

   // Request payload, last declared field in the lowest bits.
   typedef struct packed {
      logic [3:0]        pad;
      logic [7:0]        label_class;
      logic [7:0]        predicted_class;
      logic signed [7:0] temperature;
      logic [31:0]       rtt_ms;
      logic              alive;
      logic [7:0]        acc_class2;
      logic [7:0]        acc_class1;
      logic [7:0]        acc_class0;
      logic [2:0]        node;
   } req_data_type;

   // Response payload, last declared field in the lowest bits.
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] infer_count;
      logic [7:0]  own_acc2;
      logic [7:0]  own_acc1;
      logic [7:0]  own_acc0;
      logic        run_local;
      logic [7:0]  expert_node;
      logic [1:0]  route_class;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic write_tbl;
      logic infer_init;
      logic scan_start;
      logic scan_take;
      logic scan_next;
      logic count_inc;
      logic fb_update;
      logic cls_clear;
      logic cls_default;
      logic mul_load;
      logic recalc_start;
      logic recalc_take;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       fb_ok;
      logic       scan_end;
      logic       cand;
      logic       div_done;
      logic       div_busy;
      logic       total_zero;
      logic       cls_end;
      logic       out_free;
   } sts_type;

endpackage

### design/erws_div.sv
module erws_div import erws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic                 busy,
   output logic [QUO_W-1:0]     quo,
   output logic                 sat
);

   // Restoring division that only resolves quotients below 2**QUO_W.
   // The first step checks num >= den << QUO_W and flags saturation.
   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [DIV_NUM_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] dsh_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic                 sat_ff;
   logic                 ge;
   logic                 top_step;

   assign ge       = rem_ff >= dsh_ff;
   assign top_step = step_ff == STEP_W'(QUO_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(QUO_W);
         end else if (busy_ff) begin
            if (top_step && ge) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= {den, {QUO_W{1'b0}}};
         quo_ff <= '0;
         sat_ff <= 1'b0;
      end else if (busy_ff) begin
         if (top_step) begin
            if (ge) begin
               sat_ff <= 1'b1;
            end
         end else begin
            if (ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            quo_ff <= {quo_ff[QUO_W-2:0], ge};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign done = done_ff;
   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign sat  = sat_ff;

endmodule

### design/erws_dp.sv
module erws_dp import erws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_data_type req_data,
   input  logic [2:0]   req_func,
   input  cmd_type      cmd,
   output sts_type      sts,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   // Captured request.
   req_data_type req_ff;
   logic [2:0]   func_ff;

   // Node table.
   logic [23:0] peer_acc_ff [NODE_COUNT];
   logic        peer_valid_ff [NODE_COUNT];
   logic        node_up_ff [NODE_COUNT];
   logic [31:0] node_rtt_ff [NODE_COUNT];

   // Own statistics.
   logic [31:0] own_total_ff;
   logic [31:0] own_correct_ff [CLASS_COUNT];
   logic [7:0]  own_acc_ff [CLASS_COUNT];

   // Scan and recompute working registers.
   logic [IDX_W-1:0]  idx_ff;
   logic [CLS_W-1:0]  cls_ff;
   logic [1:0]        gate_ff;
   logic [7:0]        best_ff;
   logic [7:0]        expert_ff;
   logic [PROD_W-1:0] prod_ff;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   logic [NODE_W-1:0]    ix;
   logic [NODE_W-1:0]    wr_ix;
   logic                 node_ok;
   logic [CLS_W-1:0]     pred_ix;
   logic [1:0]           gate_calc;
   logic [23:0]          cand_acc;
   logic [7:0]           cand_gate_acc;
   logic [31:0]          rtt_eff;
   logic [DIV_DEN_W-1:0] mpp_den;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_start;
   logic                 div_done;
   logic                 div_busy;
   logic [QUO_W-1:0]     div_quo;
   logic                 div_sat;
   logic [8:0]           diff;
   logic                 win;
   logic                 is_infer;
   logic                 run_local;

   assign ix      = idx_ff[NODE_W-1:0];
   assign wr_ix   = NODE_W'(req_ff.node);
   assign node_ok = {5'b0, req_ff.node} < 8'(NODE_COUNT);
   assign pred_ix = req_ff.predicted_class[CLS_W-1:0];

   always_comb begin
      if (req_ff.temperature < cfg.cold_limit) begin
         gate_calc = 2'd0;
      end else if (req_ff.temperature < cfg.warm_limit) begin
         gate_calc = 2'd1;
      end else begin
         gate_calc = 2'd2;
      end
   end

   assign cand_acc = peer_acc_ff[ix];

   always_comb begin
      case (gate_ff)
         2'd0:    cand_gate_acc = cand_acc[7:0];
         2'd1:    cand_gate_acc = cand_acc[15:8];
         default: cand_gate_acc = cand_acc[23:16];
      endcase
   end

   assign rtt_eff = (node_rtt_ff[ix] == RTT_UNKNOWN) ? cfg.unknown_rtt_ms : node_rtt_ff[ix];
   assign mpp_den = (cfg.ms_per_point == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(cfg.ms_per_point);

   // The divider serves both the rtt penalty and the accuracy ratio.
   assign div_start = cmd.scan_start | cmd.recalc_start;
   assign div_num   = cmd.recalc_start ? DIV_NUM_W'(prod_ff) : DIV_NUM_W'(rtt_eff);
   assign div_den   = cmd.recalc_start ? (DIV_DEN_W'(own_total_ff) + DIV_DEN_W'(1)) : mpp_den;

   erws_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .busy  (div_busy),
      .quo   (div_quo),
      .sat   (div_sat)
   );

   // Utility beats the best so far only when accuracy exceeds the penalty by more than best.
   assign diff = {1'b0, cand_gate_acc} - {1'b0, div_quo};
   assign win  = !div_sat && !diff[8] && (diff[7:0] > best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NODE_COUNT; n++) begin
            peer_valid_ff[n] <= 1'b0;
            node_up_ff[n]    <= 1'b0;
            node_rtt_ff[n]   <= RTT_UNKNOWN;
         end
         own_total_ff <= '0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            own_correct_ff[c] <= '0;
            own_acc_ff[c]     <= DEFAULT_ACC;
         end
         idx_ff       <= '0;
         cls_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.write_tbl && node_ok) begin
            if (func_ff == FUNC_PEER) begin
               peer_valid_ff[wr_ix] <= 1'b1;
            end else begin
               node_up_ff[wr_ix]  <= req_ff.alive;
               node_rtt_ff[wr_ix] <= req_ff.rtt_ms;
            end
         end
         if (cmd.infer_init) begin
            idx_ff <= '0;
         end else if (cmd.scan_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.count_inc) begin
            own_total_ff <= own_total_ff + 1'b1;
         end
         if (cmd.fb_update && (req_ff.predicted_class == req_ff.label_class)) begin
            own_correct_ff[pred_ix] <= own_correct_ff[pred_ix] + 1'b1;
         end
         if (cmd.cls_clear) begin
            cls_ff <= '0;
         end else if (cmd.cls_default || cmd.recalc_take) begin
            cls_ff <= cls_ff + 1'b1;
         end
         if (cmd.cls_default) begin
            own_acc_ff[cls_ff] <= DEFAULT_ACC;
         end else if (cmd.recalc_take) begin
            own_acc_ff[cls_ff] <= div_sat ? ACC_SATURATED : div_quo;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign is_infer  = func_ff == FUNC_INFER;
   assign run_local = (expert_ff == cfg.own_node) || (cfg.own_node == OWN_UNASSIGNED);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         func_ff <= req_func;
      end
      if (cmd.write_tbl && node_ok && (func_ff == FUNC_PEER)) begin
         peer_acc_ff[wr_ix] <= {req_ff.acc_class2, req_ff.acc_class1, req_ff.acc_class0};
      end
      if (cmd.infer_init) begin
         gate_ff   <= gate_calc;
         best_ff   <= own_acc_ff[gate_calc];
         expert_ff <= cfg.own_node;
      end else if (cmd.scan_take && win) begin
         best_ff   <= diff[7:0];
         expert_ff <= 8'(idx_ff);
      end
      if (cmd.mul_load) begin
         prod_ff <= PROD_W'(own_correct_ff[cls_ff]) * PROD_W'(PCT_SCALE);
      end
      if (cmd.out_load) begin
         rsp_data_ff.pad         <= '0;
         rsp_data_ff.route_class <= is_infer ? gate_ff : 2'd0;
         rsp_data_ff.expert_node <= is_infer ? expert_ff : 8'd0;
         rsp_data_ff.run_local   <= is_infer ? run_local : 1'b0;
         rsp_data_ff.own_acc0    <= own_acc_ff[0];
         rsp_data_ff.own_acc1    <= own_acc_ff[1];
         rsp_data_ff.own_acc2    <= own_acc_ff[2];
         rsp_data_ff.infer_count <= own_total_ff;
      end
   end

   always_comb begin
      sts.func       = func_ff;
      sts.fb_ok      = req_ff.predicted_class < 8'(CLASS_COUNT);
      sts.scan_end   = idx_ff == IDX_W'(NODE_COUNT);
      sts.cand       = peer_valid_ff[ix] && node_up_ff[ix] && (8'(idx_ff) != cfg.own_node);
      sts.div_done   = div_done;
      sts.div_busy   = div_busy;
      sts.total_zero = own_total_ff == '0;
      sts.cls_end    = cls_ff == CLS_W'(CLASS_COUNT);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/erws_ctrl.sv
module erws_ctrl import erws_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SDIV,
      ST_RECALC,
      ST_RMUL,
      ST_RDIV,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.func)
               FUNC_PEER, FUNC_STATUS: begin
                  cmd.write_tbl = 1'b1;
                  state_in      = ST_IDLE;
               end
               FUNC_INFER: begin
                  cmd.infer_init = 1'b1;
                  state_in       = ST_SCAN;
               end
               FUNC_FEEDBACK: begin
                  if (sts.fb_ok) begin
                     cmd.fb_update = 1'b1;
                     cmd.cls_clear = 1'b1;
                     state_in      = ST_RECALC;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               FUNC_REFRESH: begin
                  cmd.cls_clear = 1'b1;
                  state_in      = ST_RECALC;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               cmd.count_inc = 1'b1;
               state_in      = ST_OUT;
            end else if (sts.cand) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SDIV;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_SDIV: begin
            if (sts.div_done) begin
               cmd.scan_take = 1'b1;
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_RECALC: begin
            if (sts.cls_end) begin
               state_in = ST_OUT;
            end else if (sts.total_zero) begin
               cmd.cls_default = 1'b1;
            end else begin
               cmd.mul_load = 1'b1;
               state_in     = ST_RMUL;
            end
         end
         ST_RMUL: begin
            cmd.recalc_start = 1'b1;
            state_in         = ST_RDIV;
         end
         ST_RDIV: begin
            if (sts.div_done) begin
               cmd.recalc_take = 1'b1;
               state_in        = ST_RECALC;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/expert_router_with_scores_top.sv
// Expert router: picks the node that should run an inference request. Each request
// transfer carries a function code in req_tuser: peer score (store a node's three
// class accuracies), node status (alive flag and round-trip time), infer (sort the
// temperature into class 0, 1 or 2 and choose the node with the highest utility,
// accuracy minus rtt divided by ms_per_point, where this node itself pays no
// penalty and ties keep the earlier candidate), feedback (count a correct
// prediction and recompute own accuracies) and refresh (recompute only). Infer,
// feedback and refresh each produce one response transfer; table writes and
// unknown codes produce none. One request is worked on at a time. Infer steps
// through every table node, skips those that are not candidates and runs the
// divider once per candidate. Feedback and refresh run the divider once per
// class, or set each class to the default accuracy while no inference has been
// counted; feedback for a class out of range skips the recompute. The shared
// divider resolves only quotients below 256 and flags anything larger at its
// first step. A finished response sits in an output register, so the next
// request is taken while the response waits for rsp_tready; a request that
// finishes while that register is still full waits for it to drain. Control
// registers are written through the csr_ port and should change only while the
// block is idle.
module expert_router_with_scores_top import erws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // node, acc_class0, acc_class1, acc_class2, alive, rtt_ms, temperature,
   // predicted_class, label_class, from bit 0 up; top four bits zero
   input  logic [87:0]           req_tdata,
   // func
   input  logic [2:0]            req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // route_class, expert_node, run_local, own_acc0, own_acc1, own_acc2,
   // infer_count, from bit 0 up; top five bits zero
   output logic [71:0]           rsp_tdata,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg_ff;
   cmd_type      cmd;
   sts_type      sts;
   rsp_data_type rsp_data;
   rsp_data_type rsp_view;
   logic         csr_write;
   logic [2:0]   csr_index;

   // Control registers. A write lands in the access phase; pready never stalls.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_node       <= OWN_NODE_RESET;
         cfg_ff.cold_limit     <= COLD_LIMIT_RESET;
         cfg_ff.warm_limit     <= WARM_LIMIT_RESET;
         cfg_ff.unknown_rtt_ms <= UNKNOWN_RTT_RESET;
         cfg_ff.ms_per_point   <= MS_PER_POINT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_OWN_NODE:     cfg_ff.own_node       <= csr_pwdata[7:0];
            REG_COLD_LIMIT:   cfg_ff.cold_limit     <= csr_pwdata[7:0];
            REG_WARM_LIMIT:   cfg_ff.warm_limit     <= csr_pwdata[7:0];
            REG_UNKNOWN_RTT:  cfg_ff.unknown_rtt_ms <= csr_pwdata;
            REG_MS_PER_POINT: cfg_ff.ms_per_point   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Reads return the stored value; the signed limits come back as raw bytes.
   always_comb begin
      case (csr_index)
         REG_OWN_NODE:     csr_prdata = 32'(cfg_ff.own_node);
         REG_COLD_LIMIT:   csr_prdata = {24'b0, cfg_ff.cold_limit};
         REG_WARM_LIMIT:   csr_prdata = {24'b0, cfg_ff.warm_limit};
         REG_UNKNOWN_RTT:  csr_prdata = cfg_ff.unknown_rtt_ms;
         REG_MS_PER_POINT: csr_prdata = cfg_ff.ms_per_point;
         default:          csr_prdata = '0;
      endcase
   end

   // The controller sequences table writes, the node scan and the accuracy
   // recompute; the datapath holds every table, counter and the divider.
   erws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   erws_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_tdata),
      .req_func  (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;
   assign rsp_view  = rsp_tdata;

   // The gate only ever produces classes 0 to 2.
   a_gate_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_view.route_class != 2'd3)
      else $error("gate class out of range");

   // A remote expert must be a real node of the table.
   a_remote_expert_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_view.run_local |-> rsp_view.expert_node < 8'(NODE_COUNT))
      else $error("remote expert is not a table node");

   // The controller only takes a request when the divider is quiet.
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.div_busy)
      else $error("request taken while the divider is busy");

   // Requests are worked on one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken back to back");

endmodule
